// ----- rtl/jsu_pkg.sv -----
`timescale 1ns / 1ps

package jsu_pkg;

   // Result kinds
   localparam logic [1:0] KIND_DATA  = 2'd0;
   localparam logic [1:0] KIND_CLOSE = 2'd1;
   localparam logic [1:0] KIND_ERROR = 2'd2;

   // Error codes
   localparam logic [1:0] ERR_ESCAPE  = 2'd0;
   localparam logic [1:0] ERR_UNICODE = 2'd1;
   localparam logic [1:0] ERR_UNTERM  = 2'd2;

   localparam logic [20:0] CP_REPLACEMENT = 21'h00FFFD;

   typedef struct packed {
      logic [7:0] in_byte;
      logic       text_ends;
   } req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic [1:0] kind;
      logic [1:0] error_code;
      logic       last_of_run;
   } rsp_type;

   // Middle item of a run: nothing, one raw byte, or a code point to encode
   typedef enum logic [1:0] {
      MAIN_NONE,
      MAIN_RAW,
      MAIN_CP
   } main_type;

   // One run of results: [U+FFFD] [main item] [close or error marker]
   typedef struct packed {
      logic        pre;
      main_type    main_sel;
      logic [20:0] value;
      logic        has_tail;
      logic [1:0]  tail_kind;
      logic [1:0]  tail_err;
   } desc_type;

endpackage

// ----- rtl/jsu_front.sv -----
`timescale 1ns / 1ps

module jsu_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  jsu_pkg::req_type  req_data,
   input  logic              q_full,
   output logic              q_push,
   output jsu_pkg::desc_type q_data
);
   import jsu_pkg::*;

   typedef enum logic [2:0] {
      MODE_PLAIN,
      MODE_ESC,
      MODE_HEX1,
      MODE_WAIT_BS,
      MODE_WAIT_U,
      MODE_HEX2
   } mode_type;

   localparam logic [7:0] CH_QUOTE  = 8'h22;
   localparam logic [7:0] CH_SLASH  = 8'h2F;
   localparam logic [7:0] CH_BSLASH = 8'h5C;
   localparam logic [7:0] CH_B      = 8'h62;
   localparam logic [7:0] CH_F      = 8'h66;
   localparam logic [7:0] CH_N      = 8'h6E;
   localparam logic [7:0] CH_R      = 8'h72;
   localparam logic [7:0] CH_T      = 8'h74;
   localparam logic [7:0] CH_U      = 8'h75;

   mode_type    mode_ff, mode_in, eff_mode;
   logic [1:0]  hex_count_ff, hex_count_in;
   logic [15:0] code_unit_ff, code_unit_in;
   logic [9:0]  high_half_ff, high_half_in;
   desc_type    desc;
   logic        halt;
   logic        unit_done;
   logic [4:0]  hex;
   logic [15:0] new_unit;
   logic [7:0]  b;
   logic        ends;
   logic        accept;

   // {valid, value} of one hex digit
   function automatic logic [4:0] hex_digit(input logic [7:0] c);
      logic [4:0] r;
      r = 5'd0;
      if (c >= 8'h30 && c <= 8'h39) begin
         r = {1'b1, 4'(c - 8'h30)};
      end else if (c >= 8'h61 && c <= 8'h66) begin
         r = {1'b1, 4'(c - 8'h57)};
      end else if (c >= 8'h41 && c <= 8'h46) begin
         r = {1'b1, 4'(c - 8'h37)};
      end
      return r;
   endfunction

   assign b         = req_data.in_byte;
   assign ends      = req_data.text_ends;
   assign req_ready = !q_full;
   assign accept    = req_valid && req_ready;
   assign hex       = hex_digit(b);
   assign new_unit  = {code_unit_ff[11:0], hex[3:0]};

   always_comb begin
      mode_in      = mode_ff;
      hex_count_in = hex_count_ff;
      code_unit_in = code_unit_ff;
      high_half_in = high_half_ff;
      desc         = '0;
      halt         = 1'b0;
      unit_done    = 1'b0;
      eff_mode     = mode_ff;

      // Unmatched partner of a high surrogate: emit U+FFFD, redo the byte
      if (mode_ff == MODE_WAIT_BS && b != CH_BSLASH) begin
         desc.pre = 1'b1;
         eff_mode = MODE_PLAIN;
      end
      if (mode_ff == MODE_WAIT_U && b != CH_U) begin
         desc.pre = 1'b1;
         eff_mode = MODE_ESC;
      end

      case (eff_mode)
         MODE_ESC: begin
            mode_in = MODE_PLAIN;
            desc.main_sel = MAIN_RAW;
            case (b)
               CH_QUOTE, CH_BSLASH, CH_SLASH: desc.value = {13'd0, b};
               CH_B: desc.value = 21'h08;
               CH_F: desc.value = 21'h0C;
               CH_N: desc.value = 21'h0A;
               CH_R: desc.value = 21'h0D;
               CH_T: desc.value = 21'h09;
               CH_U: begin
                  desc.main_sel = MAIN_NONE;
                  mode_in       = MODE_HEX1;
                  hex_count_in  = 2'd0;
                  code_unit_in  = 16'd0;
               end
               default: begin
                  desc.main_sel = MAIN_NONE;
                  desc.has_tail = 1'b1;
                  desc.tail_err = ERR_ESCAPE;
                  halt          = 1'b1;
               end
            endcase
            if (ends && !halt) begin
               desc.has_tail = 1'b1;
               desc.tail_err = (b == CH_U) ? ERR_UNICODE : ERR_UNTERM;
               halt          = 1'b1;
            end
            if (desc.has_tail) begin
               desc.tail_kind = KIND_ERROR;
            end
         end
         MODE_HEX1, MODE_HEX2: begin
            if (!hex[4]) begin
               desc.pre       = (mode_ff == MODE_HEX2) && ends;
               desc.has_tail  = 1'b1;
               desc.tail_kind = KIND_ERROR;
               desc.tail_err  = ERR_UNICODE;
               halt           = 1'b1;
            end else if (hex_count_ff != 2'd3) begin
               hex_count_in = hex_count_ff + 2'd1;
               code_unit_in = new_unit;
               if (ends) begin
                  desc.pre       = (mode_ff == MODE_HEX2);
                  desc.has_tail  = 1'b1;
                  desc.tail_kind = KIND_ERROR;
                  desc.tail_err  = ERR_UNICODE;
                  halt           = 1'b1;
               end
            end else begin
               hex_count_in = 2'd0;
               code_unit_in = new_unit;
               if (mode_ff == MODE_HEX1) begin
                  unit_done = 1'b1;
               end else if (new_unit[15:10] == 6'b110111) begin
                  // Join the pair
                  desc.main_sel = MAIN_CP;
                  desc.value    = 21'h10000 + {1'b0, high_half_ff, new_unit[9:0]};
                  mode_in       = MODE_PLAIN;
                  if (ends) begin
                     desc.has_tail  = 1'b1;
                     desc.tail_kind = KIND_ERROR;
                     desc.tail_err  = ERR_UNTERM;
                     halt           = 1'b1;
                  end
               end else begin
                  desc.pre  = 1'b1;
                  unit_done = 1'b1;
               end
            end
         end
         MODE_WAIT_BS: begin
            mode_in = MODE_WAIT_U;
            if (ends) begin
               desc.main_sel  = MAIN_CP;
               desc.value     = CP_REPLACEMENT;
               desc.has_tail  = 1'b1;
               desc.tail_kind = KIND_ERROR;
               desc.tail_err  = ERR_UNTERM;
               halt           = 1'b1;
            end
         end
         MODE_WAIT_U: begin
            mode_in      = MODE_HEX2;
            hex_count_in = 2'd0;
            code_unit_in = 16'd0;
            if (ends) begin
               desc.main_sel  = MAIN_CP;
               desc.value     = CP_REPLACEMENT;
               desc.has_tail  = 1'b1;
               desc.tail_kind = KIND_ERROR;
               desc.tail_err  = ERR_UNICODE;
               halt           = 1'b1;
            end
         end
         default: begin
            mode_in = MODE_PLAIN;
            case (b)
               CH_QUOTE: begin
                  desc.has_tail  = 1'b1;
                  desc.tail_kind = KIND_CLOSE;
                  halt           = 1'b1;
               end
               CH_BSLASH: begin
                  mode_in = MODE_ESC;
               end
               default: begin
                  desc.main_sel = MAIN_RAW;
                  desc.value    = {13'd0, b};
               end
            endcase
            if (ends && b != CH_QUOTE) begin
               desc.has_tail  = 1'b1;
               desc.tail_kind = KIND_ERROR;
               desc.tail_err  = ERR_UNTERM;
               halt           = 1'b1;
            end
         end
      endcase

      // A complete unit taken on its own
      if (unit_done) begin
         if (new_unit[15:10] == 6'b110110) begin
            high_half_in = new_unit[9:0];
            mode_in      = MODE_WAIT_BS;
            if (ends) begin
               desc.main_sel = MAIN_CP;
               desc.value    = CP_REPLACEMENT;
            end
         end else begin
            desc.main_sel = MAIN_CP;
            desc.value    = (new_unit[15:10] == 6'b110111) ? CP_REPLACEMENT
                                                          : {5'd0, new_unit};
            mode_in       = MODE_PLAIN;
         end
         if (ends) begin
            desc.has_tail  = 1'b1;
            desc.tail_kind = KIND_ERROR;
            desc.tail_err  = ERR_UNTERM;
            halt           = 1'b1;
         end
      end

      // Close or error: drop all state
      if (halt) begin
         mode_in      = MODE_PLAIN;
         hex_count_in = 2'd0;
         code_unit_in = 16'd0;
         high_half_in = 10'd0;
      end
   end

   assign q_data = desc;
   assign q_push = accept &&
                   (desc.pre || desc.main_sel != MAIN_NONE || desc.has_tail);

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= MODE_PLAIN;
         hex_count_ff <= 2'd0;
         code_unit_ff <= 16'd0;
         high_half_ff <= 10'd0;
      end else if (accept) begin
         mode_ff      <= mode_in;
         hex_count_ff <= hex_count_in;
         code_unit_ff <= code_unit_in;
         high_half_ff <= high_half_in;
      end
   end

   a_halt_clears: assert property (@(posedge clock) disable iff (reset)
      (accept && halt) |=> (mode_ff == MODE_PLAIN && hex_count_ff == 2'd0))
      else $error("state not cleared after close or error");

   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      q_full |-> !q_push)
      else $error("push into full queue");

endmodule

// ----- rtl/jsu_fifo.sv -----
`timescale 1ns / 1ps

module jsu_fifo #(
   parameter int DEPTH = 4
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  jsu_pkg::desc_type push_data,
   output logic              full,
   input  logic              pop,
   output logic              empty,
   output jsu_pkg::desc_type head
);
   import jsu_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

   desc_type         store_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [CNT_W-1:0] count_ff;

   assign full  = (count_ff == FULL_CNT);
   assign empty = (count_ff == '0);
   assign head  = store_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (push) begin
         store_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
         end
         if (push && !pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (pop && !push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      pop |-> !empty)
      else $error("pop from empty queue");

endmodule

// ----- rtl/jsu_back.sv -----
`timescale 1ns / 1ps

module jsu_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              head_valid,
   input  jsu_pkg::desc_type head,
   output logic              pop,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output jsu_pkg::rsp_type  rsp_data
);
   import jsu_pkg::*;

   logic [2:0] idx_ff, idx_in;
   logic       rsp_valid_ff;
   rsp_type    rsp_ff, item;
   logic [2:0] pre_n, main_n;
   logic [3:0] total;
   logic [2:0] j;
   logic       last;
   logic       advance;

   function automatic logic [2:0] utf8_len(input logic [20:0] cp);
      logic [2:0] n;
      if (cp <= 21'h7F) begin
         n = 3'd1;
      end else if (cp <= 21'h7FF) begin
         n = 3'd2;
      end else if (cp <= 21'hFFFF) begin
         n = 3'd3;
      end else begin
         n = 3'd4;
      end
      return n;
   endfunction

   function automatic logic [7:0] utf8_byte(input logic [20:0] cp,
                                            input logic [2:0] len,
                                            input logic [1:0] k);
      logic [7:0] r;
      r = cp[7:0];
      case (len)
         3'd2: r = (k == 2'd0) ? {3'b110, cp[10:6]} : {2'b10, cp[5:0]};
         3'd3: begin
            case (k)
               2'd0:    r = {4'b1110, cp[15:12]};
               2'd1:    r = {2'b10, cp[11:6]};
               default: r = {2'b10, cp[5:0]};
            endcase
         end
         3'd4: begin
            case (k)
               2'd0:    r = {5'b11110, cp[20:18]};
               2'd1:    r = {2'b10, cp[17:12]};
               2'd2:    r = {2'b10, cp[11:6]};
               default: r = {2'b10, cp[5:0]};
            endcase
         end
         default: r = cp[7:0];
      endcase
      return r;
   endfunction

   always_comb begin
      pre_n = head.pre ? 3'd3 : 3'd0;
      case (head.main_sel)
         MAIN_RAW: main_n = 3'd1;
         MAIN_CP:  main_n = utf8_len(head.value);
         default:  main_n = 3'd0;
      endcase
      total = {1'b0, pre_n} + {1'b0, main_n} + {3'd0, head.has_tail};
      j     = idx_ff - pre_n;
      last  = ({1'b0, idx_ff} == total - 4'd1);

      item = '0;
      item.kind = KIND_DATA;
      if (idx_ff < pre_n) begin
         item.out_byte = utf8_byte(CP_REPLACEMENT, 3'd3, idx_ff[1:0]);
      end else if (j < main_n) begin
         item.out_byte = (head.main_sel == MAIN_RAW) ? head.value[7:0]
                                                     : utf8_byte(head.value, main_n, j[1:0]);
      end else begin
         item.kind       = head.tail_kind;
         item.error_code = head.tail_err;
      end
      item.last_of_run = last;
   end

   // Advance whenever the output register is empty or being drained
   assign advance = !rsp_valid_ff || rsp_ready;
   assign pop     = advance && head_valid && last;
   assign idx_in  = last ? 3'd0 : idx_ff + 3'd1;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         idx_ff       <= 3'd0;
      end else if (advance) begin
         rsp_valid_ff <= head_valid;
         if (head_valid) begin
            idx_ff <= idx_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance && head_valid) begin
         rsp_ff <= item;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   a_idx_in_run: assert property (@(posedge clock) disable iff (reset)
      head_valid |-> ({1'b0, idx_ff} < total))
      else $error("run index beyond run length");

   a_marker_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.kind != KIND_DATA) |-> rsp_ff.last_of_run)
      else $error("close or error marker not last of run");

endmodule

// ----- rtl/json_string_unescape_utf8.sv -----
`timescale 1ns / 1ps

// JSON string body unescaper with UTF-8 output.
// req channel: one beat per byte of the string body after the opening quote,
//   with text_ends set on the final byte of the text.
// rsp channel: one beat per result byte or marker: data bytes (kind 0), a
//   close marker (kind 1) or an error (kind 2); last_of_run flags the final
//   beat caused by one req beat. A req beat may cause no beat at all.
// Throughput: one req beat per cycle while the queue has room, and one rsp
//   beat per cycle while rsp_ready is high; a byte that expands to N beats
//   (up to 7, e.g. U+FFFD followed by a three-byte character and an error)
//   holds the output side for all N beats, and the queue of FIFO_DEPTH runs
//   absorbs such bursts.
// Reset: all decoder state returns to plain string content and the queue and
//   output register empty. The block also clears its own state after every
//   close or error, so the next byte starts a new string body.
// Stall: while rsp_ready is low the output register holds its beat; the front
//   end keeps accepting bytes until the queue fills, then drops req_ready.
module json_string_unescape_utf8 #(
   parameter int FIFO_DEPTH = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  jsu_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output jsu_pkg::rsp_type rsp_data
);
   import jsu_pkg::*;

   desc_type push_data, head;
   logic     push, full, pop, empty;

   // Front: decode state machine, at most one run descriptor per byte
   jsu_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .q_full    (full),
      .q_push    (push),
      .q_data    (push_data)
   );

   // Queue of pending runs
   jsu_fifo #(
      .DEPTH (FIFO_DEPTH)
   ) u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .full      (full),
      .pop       (pop),
      .empty     (empty),
      .head      (head)
   );

   // Back: expand each run into output beats
   jsu_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (!empty),
      .head       (head),
      .pop        (pop),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_data   (rsp_data)
   );

endmodule

// ----- bench/json_string_unescape_utf8_check.sv -----
`timescale 1ns / 1ps

module json_string_unescape_utf8_check (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  logic             req_ready,
   input  jsu_pkg::req_type req_data,
   input  logic             rsp_valid,
   input  logic             rsp_ready,
   input  jsu_pkg::rsp_type rsp_data,
   output int               fault_count,
   output int               open_count
);
   import jsu_pkg::*;

   localparam logic [15:0] HIGH_SURR_FIRST = 16'hD800;
   localparam logic [15:0] HIGH_SURR_LAST  = 16'hDBFF;
   localparam logic [15:0] LOW_SURR_FIRST  = 16'hDC00;
   localparam logic [15:0] LOW_SURR_LAST   = 16'hDFFF;
   localparam logic [20:0] SUPP_BASE       = 21'h10000;
   localparam int          RUN_MAX         = 8;
   localparam int          REPORT_MAX      = 10;

   localparam logic [7:0] CH_QUOTE  = 8'h22;
   localparam logic [7:0] CH_BSLASH = 8'h5C;

   typedef enum logic [2:0] {
      SCAN_TEXT,
      SCAN_ESCAPE,
      SCAN_HEX_FIRST,
      SCAN_WAIT_BSLASH,
      SCAN_WAIT_U,
      SCAN_HEX_SECOND
   } scan_state_type;

   scan_state_type scan_state;
   logic [1:0]     digit_count;
   logic [15:0]    unit_acc;
   logic [9:0]     high_bits;

   rsp_type run_beats[$];
   rsp_type expected_beats[$];
   logic    string_done;
   rsp_type want;
   int      mismatches = 0;

   function automatic void clear_decoder();
      scan_state  = SCAN_TEXT;
      digit_count = '0;
      unit_acc    = '0;
      high_bits   = '0;
   endfunction

   function automatic void emit(logic [7:0] b, logic [1:0] kind, logic [1:0] err);
      rsp_type beat;
      if (run_beats.size() >= RUN_MAX) return;
      beat.out_byte    = b;
      beat.kind        = kind;
      beat.error_code  = err;
      beat.last_of_run = 1'b0;
      run_beats.insert(run_beats.size(), beat);
   endfunction

   function automatic void abort(logic [1:0] err);
      emit(8'h00, KIND_ERROR, err);
      string_done = 1'b1;
   endfunction

   function automatic void emit_utf8(logic [20:0] cp);
      if (cp <= 21'h7F) begin
         emit(cp[7:0], KIND_DATA, ERR_ESCAPE);
      end else if (cp <= 21'h7FF) begin
         emit({3'b110, cp[10:6]}, KIND_DATA, ERR_ESCAPE);
         emit({2'b10, cp[5:0]}, KIND_DATA, ERR_ESCAPE);
      end else if (cp <= 21'hFFFF) begin
         emit({4'b1110, cp[15:12]}, KIND_DATA, ERR_ESCAPE);
         emit({2'b10, cp[11:6]}, KIND_DATA, ERR_ESCAPE);
         emit({2'b10, cp[5:0]}, KIND_DATA, ERR_ESCAPE);
      end else begin
         emit({5'b11110, cp[20:18]}, KIND_DATA, ERR_ESCAPE);
         emit({2'b10, cp[17:12]}, KIND_DATA, ERR_ESCAPE);
         emit({2'b10, cp[11:6]}, KIND_DATA, ERR_ESCAPE);
         emit({2'b10, cp[5:0]}, KIND_DATA, ERR_ESCAPE);
      end
   endfunction

   // bit 4 flags a hex digit, bits 3:0 hold its value
   function automatic logic [4:0] hex_digit(logic [7:0] b);
      logic [7:0] d;
      d = 8'h00;
      if (b >= "0" && b <= "9") begin
         d = b - "0";
         return {1'b1, d[3:0]};
      end
      if (b >= "a" && b <= "f") begin
         d = b - "a" + 8'd10;
         return {1'b1, d[3:0]};
      end
      if (b >= "A" && b <= "F") begin
         d = b - "A" + 8'd10;
         return {1'b1, d[3:0]};
      end
      return 5'b0;
   endfunction

   function automatic void take_unit(logic [15:0] cu, logic ends);
      if (cu >= HIGH_SURR_FIRST && cu <= HIGH_SURR_LAST) begin
         high_bits  = cu[9:0];
         scan_state = SCAN_WAIT_BSLASH;
         if (ends) begin
            emit_utf8(CP_REPLACEMENT);
            abort(ERR_UNTERM);
         end
         return;
      end
      if (cu >= LOW_SURR_FIRST && cu <= LOW_SURR_LAST) emit_utf8(CP_REPLACEMENT);
      else emit_utf8({5'b0, cu});
      scan_state = SCAN_TEXT;
      if (ends) abort(ERR_UNTERM);
   endfunction

   function automatic void text_byte(logic [7:0] b, logic ends);
      if (b == CH_QUOTE) begin
         emit(8'h00, KIND_CLOSE, ERR_ESCAPE);
         string_done = 1'b1;
         return;
      end
      if (b == CH_BSLASH) begin
         scan_state = SCAN_ESCAPE;
         if (ends) abort(ERR_UNTERM);
         return;
      end
      emit(b, KIND_DATA, ERR_ESCAPE);
      scan_state = SCAN_TEXT;
      if (ends) abort(ERR_UNTERM);
   endfunction

   function automatic void escape_byte(logic [7:0] b, logic ends);
      logic [7:0] v;
      case (b)
         CH_QUOTE, CH_BSLASH, "/": v = b;
         "b": v = 8'h08;
         "f": v = 8'h0C;
         "n": v = 8'h0A;
         "r": v = 8'h0D;
         "t": v = 8'h09;
         "u": begin
            scan_state  = SCAN_HEX_FIRST;
            digit_count = '0;
            unit_acc    = '0;
            if (ends) abort(ERR_UNICODE);
            return;
         end
         default: begin
            abort(ERR_ESCAPE);
            return;
         end
      endcase
      emit(v, KIND_DATA, ERR_ESCAPE);
      scan_state = SCAN_TEXT;
      if (ends) abort(ERR_UNTERM);
   endfunction

   function automatic void hex_byte(logic [7:0] b, logic ends, logic second);
      logic [4:0] d;
      d = hex_digit(b);
      if (!d[4]) begin
         if (second && ends) emit_utf8(CP_REPLACEMENT);
         abort(ERR_UNICODE);
         return;
      end
      unit_acc = {unit_acc[11:0], d[3:0]};
      if (digit_count < 2'd3) begin
         digit_count = digit_count + 2'd1;
         if (ends) begin
            if (second) emit_utf8(CP_REPLACEMENT);
            abort(ERR_UNICODE);
         end
         return;
      end
      digit_count = '0;
      if (!second) begin
         take_unit(unit_acc, ends);
         return;
      end
      if (unit_acc >= LOW_SURR_FIRST && unit_acc <= LOW_SURR_LAST) begin
         emit_utf8(SUPP_BASE + {1'b0, high_bits, unit_acc[9:0]});
         scan_state = SCAN_TEXT;
         if (ends) abort(ERR_UNTERM);
         return;
      end
      emit_utf8(CP_REPLACEMENT);
      take_unit(unit_acc, ends);
   endfunction

   // Work out every beat one input byte causes and queue them up.
   function automatic void decode_byte(logic [7:0] b, logic ends);
      run_beats.delete();
      string_done = 1'b0;
      case (scan_state)
         SCAN_ESCAPE:     escape_byte(b, ends);
         SCAN_HEX_FIRST:  hex_byte(b, ends, 1'b0);
         SCAN_HEX_SECOND: hex_byte(b, ends, 1'b1);
         SCAN_WAIT_BSLASH: begin
            if (b == CH_BSLASH) begin
               scan_state = SCAN_WAIT_U;
               if (ends) begin
                  emit_utf8(CP_REPLACEMENT);
                  abort(ERR_UNTERM);
               end
            end else begin
               emit_utf8(CP_REPLACEMENT);
               scan_state = SCAN_TEXT;
               text_byte(b, ends);
            end
         end
         SCAN_WAIT_U: begin
            if (b == "u") begin
               scan_state  = SCAN_HEX_SECOND;
               digit_count = '0;
               unit_acc    = '0;
               if (ends) begin
                  emit_utf8(CP_REPLACEMENT);
                  abort(ERR_UNICODE);
               end
            end else begin
               emit_utf8(CP_REPLACEMENT);
               scan_state = SCAN_ESCAPE;
               escape_byte(b, ends);
            end
         end
         default: text_byte(b, ends);
      endcase
      if (string_done) clear_decoder();
      if (run_beats.size() > 0) run_beats[run_beats.size() - 1].last_of_run = 1'b1;
      foreach (run_beats[k]) expected_beats.insert(expected_beats.size(), run_beats[k]);
   endfunction

   function automatic void report_fault(string what, rsp_type exp_beat, rsp_type got);
      string exp_text;
      string got_text;
      mismatches++;
      if (mismatches <= REPORT_MAX) begin
         exp_text = $sformatf("byte %02h kind %0d err %0d last %0d", exp_beat.out_byte,
                              exp_beat.kind, exp_beat.error_code, exp_beat.last_of_run);
         got_text = $sformatf("byte %02h kind %0d err %0d last %0d", got.out_byte,
                              got.kind, got.error_code, got.last_of_run);
         $display("%t %s: expected %s, got %s", $realtime, what, exp_text, got_text);
      end
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         clear_decoder();
         expected_beats.delete();
         mismatches = 0;
      end else begin
         if (req_valid && req_ready) decode_byte(req_data.in_byte, req_data.text_ends);
         if (rsp_valid && rsp_ready) begin
            if (expected_beats.size() == 0) begin
               report_fault("beat with nothing pending", '0, rsp_data);
            end else begin
               want = expected_beats.pop_front();
               if (rsp_data.out_byte !== want.out_byte || rsp_data.kind !== want.kind ||
                   rsp_data.error_code !== want.error_code ||
                   rsp_data.last_of_run !== want.last_of_run)
                  report_fault("beat mismatch", want, rsp_data);
            end
         end
      end
      fault_count <= mismatches;
      open_count  <= expected_beats.size();
   end

endmodule

// ----- bench/json_string_unescape_utf8_test.sv -----
`timescale 1ns / 1ps

module json_string_unescape_utf8_test;
   import jsu_pkg::*;

   localparam int RANDOM_ITEMS = 360;
   localparam int RESET_CYCLES = 9;
   localparam int MAX_GAP      = 5;
   localparam int LONG_HOLD    = 80;   // receiver hold-off, in cycles
   localparam int HOLD_AT_BEAT = 120;
   localparam int DRAIN_CYCLES = 16;
   localparam int CALM_STRETCH = 40;

   localparam logic [7:0] CH_QUOTE  = 8'h22;
   localparam logic [7:0] CH_BSLASH = 8'h5C;

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   int fault_count;
   int open_count;

   // Bytes to send, in order, with their text_ends flags.
   req_type byte_plan[$];

   json_string_unescape_utf8 dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   json_string_unescape_utf8_check watcher (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data),
      .fault_count (fault_count),
      .open_count  (open_count)
   );

   initial forever #2 clock = ~clock;

   // Hard stop in case the block hangs; far beyond the slowest legal run.
   initial begin
      #2_000_000;
      $display("== FAIL ==");
      $finish;
   end

   // ---------------------------------------------------------------------
   // Plan building
   // ---------------------------------------------------------------------

   function automatic void push_byte(logic [7:0] b, logic ends);
      req_type item;
      item.in_byte   = b;
      item.text_ends = ends;
      byte_plan.insert(byte_plan.size(), item);
   endfunction

   // Flag the most recently planned byte as the end of the text.
   function automatic void mark_end();
      byte_plan[byte_plan.size() - 1].text_ends = 1'b1;
   endfunction

   // Mix upper and lower case so both hex alphabets get exercised.
   function automatic logic [7:0] hex_char(logic [3:0] n);
      if (n < 4'd10) return "0" + n;
      if ($urandom_range(0, 1)) return "a" + n - 4'd10;
      return "A" + n - 4'd10;
   endfunction

   function automatic void push_unit(logic [15:0] u);
      push_byte(CH_BSLASH, 1'b0);
      push_byte("u", 1'b0);
      push_byte(hex_char(u[15:12]), 1'b0);
      push_byte(hex_char(u[11:8]), 1'b0);
      push_byte(hex_char(u[7:4]), 1'b0);
      push_byte(hex_char(u[3:0]), 1'b0);
   endfunction

   // Any byte that is literal string content (controls and high bytes too).
   function automatic logic [7:0] plain_char();
      logic [7:0] b;
      b = 8'($urandom_range(0, 255));
      while (b == CH_QUOTE || b == CH_BSLASH) b = 8'($urandom_range(0, 255));
      return b;
   endfunction

   function automatic logic [7:0] escape_letter();
      case ($urandom_range(0, 7))
         0:       return CH_QUOTE;
         1:       return CH_BSLASH;
         2:       return "/";
         3:       return "b";
         4:       return "f";
         5:       return "n";
         6:       return "r";
         default: return "t";
      endcase
   endfunction

   // Non-surrogate unit, spread over one-, two- and three-byte encodings.
   function automatic logic [15:0] bmp_unit();
      logic [15:0] u;
      case ($urandom_range(0, 2))
         0:       u = 16'($urandom_range(16'h0000, 16'h007F));
         1:       u = 16'($urandom_range(16'h0080, 16'h07FF));
         default: begin
            u = 16'($urandom_range(16'h0800, 16'hFFFF));
            while (u >= 16'hD800 && u <= 16'hDFFF)
               u = 16'($urandom_range(16'h0800, 16'hFFFF));
         end
      endcase
      return u;
   endfunction

   function automatic logic [15:0] high_unit();
      return 16'($urandom_range(16'hD800, 16'hDBFF));
   endfunction

   function automatic logic [15:0] low_unit();
      return 16'($urandom_range(16'hDC00, 16'hDFFF));
   endfunction

   // A string body with random content, mostly closed by a quote.
   function automatic void add_string();
      int parts;
      parts = $urandom_range(0, 8);
      for (int k = 0; k < parts; k++) begin
         case ($urandom_range(0, 9))
            0, 1, 2: push_byte(plain_char(), 1'b0);
            3: begin
               push_byte(CH_BSLASH, 1'b0);
               push_byte(escape_letter(), 1'b0);
            end
            4, 5: push_unit(bmp_unit());
            6: begin
               push_unit(high_unit());
               push_unit(low_unit());
            end
            7: push_unit(low_unit());
            // high half left for whatever comes next to pair or break
            8: push_unit(high_unit());
            default: begin
               push_unit(high_unit());
               if ($urandom_range(0, 1)) push_unit(bmp_unit());
               else push_unit(high_unit());
            end
         endcase
      end
      case ($urandom_range(0, 7))
         0:       push_byte(plain_char(), 1'b1);
         1:       push_byte(CH_QUOTE, 1'b1);
         default: push_byte(CH_QUOTE, 1'b0);
      endcase
   endfunction

   // Malformed escapes and texts that stop short.
   function automatic void add_broken();
      int digits;
      digits = $urandom_range(0, 3);
      case ($urandom_range(0, 5))
         0: begin
            push_byte(CH_BSLASH, 1'b0);
            push_byte(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0);
         end
         1: begin
            push_byte(CH_BSLASH, 1'b0);
            push_byte("u", 1'b0);
            for (int k = 0; k < digits; k++)
               push_byte(hex_char(4'($urandom_range(0, 15))), 1'b0);
            push_byte(8'("g" + $urandom_range(0, 19)), 1'($urandom_range(0, 1)));
         end
         2: begin
            push_byte(CH_BSLASH, 1'b0);
            push_byte("u", 1'b0);
            for (int k = 0; k < digits; k++)
               push_byte(hex_char(4'($urandom_range(0, 15))), 1'b0);
            mark_end();
         end
         3: begin
            push_unit(high_unit());
            push_byte(CH_BSLASH, 1'b0);
            case ($urandom_range(0, 2))
               0: mark_end();
               1: begin
                  push_byte("u", 1'b0);
                  for (int k = 0; k < digits; k++)
                     push_byte(hex_char(4'($urandom_range(0, 15))), 1'b0);
                  if ($urandom_range(0, 1)) mark_end();
                  else push_byte("z", 1'($urandom_range(0, 1)));
               end
               default: push_byte(escape_letter(), 1'($urandom_range(0, 1)));
            endcase
         end
         4: begin
            for (int k = 0; k < digits; k++) push_byte(plain_char(), 1'b0);
            if ($urandom_range(0, 1)) push_byte(CH_BSLASH, 1'b1);
            else push_byte(plain_char(), 1'b1);
         end
         default: begin
            push_unit(high_unit());
            mark_end();
         end
      endcase
   endfunction

   function automatic void add_noise();
      int count;
      count = $urandom_range(1, 4);
      for (int k = 0; k < count; k++)
         push_byte(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0);
   endfunction

   // ---------------------------------------------------------------------
   // Receiver: random stalls, calm stretches, and one long hold-off so the
   // queue fills and req_ready drops while the sender keeps offering.
   // ---------------------------------------------------------------------
   initial begin : rsp_side
      int beats;
      int gap;
      bit calm;
      beats = 0;
      calm  = 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (beats % CALM_STRETCH == 0) calm = ($urandom_range(0, 2) == 0);
         gap = calm ? 0 : $urandom_range(0, MAX_GAP);
         if (beats == HOLD_AT_BEAT) gap = LONG_HOLD;
         if (gap > 0) begin
            rsp_ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
         beats++;
      end
   end

   // ---------------------------------------------------------------------
   // Sender and verdict
   // ---------------------------------------------------------------------
   initial begin : req_side
      int  directed_count;
      int  pause_at;
      int  gap;
      bit  calm;

      // Directed opening: byte extremes, a simple escape, two- and
      // four-byte encodings, a close, an unsupported escape, early end.
      push_byte(8'h00, 1'b0);
      push_byte(8'hFF, 1'b0);
      push_byte(CH_BSLASH, 1'b0);
      push_byte("n", 1'b0);
      push_unit(16'h00E9);
      push_unit(16'hD83D);
      push_unit(16'hDE00);
      push_byte(CH_QUOTE, 1'b0);
      push_byte(CH_BSLASH, 1'b0);
      push_byte("q", 1'b0);
      push_byte("A", 1'b1);
      directed_count = byte_plan.size();

      // Random part: mostly well-formed strings, the rest noise and breakage.
      while (byte_plan.size() < directed_count + RANDOM_ITEMS) begin
         case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5, 6: add_string();
            7:                   add_noise();
            default:             add_broken();
         endcase
      end
      pause_at = directed_count + (byte_plan.size() - directed_count) * 2 / 3;

      // Release reset, then offer the plan byte by byte.
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      calm = 1'b0;
      for (int i = 0; i < byte_plan.size(); i++) begin
         // Once: hold off until every expected beat has come back.
         if (i == pause_at) begin
            req_valid <= 1'b0;
            repeat (4) @(posedge clock);
            while (open_count != 0) @(posedge clock);
         end
         if (i % CALM_STRETCH == 0) calm = ($urandom_range(0, 2) == 0);
         gap = calm ? 0 : $urandom_range(0, MAX_GAP);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         req_valid <= 1'b1;
         req_data  <= byte_plan[i];
         // Hold the beat until the block takes it.
         do @(posedge clock); while (!req_ready);
      end
      req_valid <= 1'b0;

      // Drain: wait for all pending beats, then wait DRAIN_CYCLES more so any
      // stray beat still shows up.
      repeat (4) @(posedge clock);
      while (open_count != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (fault_count == 0 && open_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
